// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the 3x3 inverse block.
// Included by files that check their own logic; no other dependency.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ----- src/m3inv_pkg.sv -----
// Shared widths and types for the 3x3 matrix inverse pipeline.
// No dependencies; used by every module of the block.
`default_nettype none
package m3inv_pkg;
   localparam int ELEM_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int N_DIM     = 3;
   localparam int N_ELEM    = N_DIM * N_DIM;
   localparam int COF_W     = 2 * ELEM_W;
   localparam int DET_W     = 3 * ELEM_W + 1;
   localparam int MAG_W     = DET_W - 1;
   localparam int SHIFT     = 2 * FRAC_BITS;
   localparam int NUM_W     = COF_W + SHIFT;
   localparam int QUO_W     = ELEM_W;
   localparam int HEAD_W    = NUM_W - QUO_W;
   localparam int DATA_W    = ((N_ELEM * ELEM_W + 7) / 8) * 8;
   localparam int USER_W    = 2;
   localparam int USER_SINGULAR  = 0;
   localparam int USER_SATURATED = 1;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef elem_type [N_DIM-1:0]     row_type;
   typedef row_type  [N_DIM-1:0]     mat_type;
   typedef logic signed [COF_W-1:0]  cof_type;
   typedef cof_type  [N_DIM-1:0]     cof_row_type;
   typedef cof_row_type [N_DIM-1:0]  cof_mat_type;
   typedef logic signed [DET_W-1:0]  det_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [QUO_W-1:0] tail;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      lane_type [N_ELEM-1:0] lane;
      logic [MAG_W-1:0]      dmag;
      logic                  singular;
   } div_type;
endpackage
`default_nettype wire

// ----- src/matrix3_inverse.sv -----
// 3x3 matrix inverse, Q16.16 in and out, adjugate over determinant.
// Pipeline: 2 cofactor, 3 determinant, 2 divider prep and 32 quotient-bit
// stages, then 1 output register.
// Throughput: one word per cycle unless the output stalls; the 32-stage bit-serial divide sets depth.
// The whole pipeline holds while a result waits untaken on the output.
// Reset (synchronous, active high) empties the pipeline; no stored state.
`default_nettype none
`include "assert_macros.svh"
module matrix3_inverse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 (32 bits each)
   input  logic [m3inv_pkg::DATA_W-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 (32 bits each)
   output logic [m3inv_pkg::DATA_W-1:0] rsp_tdata,
   // singular, saturated
   output logic [m3inv_pkg::USER_W-1:0] rsp_tuser
);
   logic                         en, cof_valid, det_valid, div_valid;
   m3inv_pkg::mat_type           in_mat, cof_mat;
   m3inv_pkg::cof_mat_type       cof, det_cof;
   m3inv_pkg::det_type           det;
   m3inv_pkg::div_type           div;
   logic                         rsp_valid_ff;
   logic [m3inv_pkg::DATA_W-1:0] rsp_data_in, rsp_data_ff;
   logic [m3inv_pkg::USER_W-1:0] rsp_user_in, rsp_user_ff;

   // advance everything when the output slot is free or being drained
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_comb begin
      for (int i = 0; i < m3inv_pkg::N_ELEM; i++)
         in_mat[i / m3inv_pkg::N_DIM][i % m3inv_pkg::N_DIM] =
            req_tdata[i * m3inv_pkg::ELEM_W +: m3inv_pkg::ELEM_W];
   end

   m3inv_cof u_cof (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_mat    (in_mat),
      .out_valid (cof_valid),
      .out_mat   (cof_mat),
      .out_cof   (cof)
   );

   m3inv_det u_det (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cof_valid),
      .in_mat    (cof_mat),
      .in_cof    (cof),
      .out_valid (det_valid),
      .out_cof   (det_cof),
      .out_det   (det)
   );

   m3inv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (det_valid),
      .in_cof    (det_cof),
      .in_det    (det),
      .out_valid (div_valid),
      .out_div   (div)
   );

   // clamp, apply sign, zero the word on a singular matrix
   always_comb begin
      logic [m3inv_pkg::QUO_W-1:0] lim, val;
      logic                        sat, any_sat;
      rsp_data_in = '0;
      any_sat     = 1'b0;
      for (int i = 0; i < m3inv_pkg::N_ELEM; i++) begin
         lim = div.lane[i].neg ? {1'b1, {(m3inv_pkg::QUO_W-1){1'b0}}}
                               : {1'b0, {(m3inv_pkg::QUO_W-1){1'b1}}};
         sat = div.lane[i].ovf || (div.lane[i].quo > lim);
         val = sat ? lim : div.lane[i].quo;
         any_sat = any_sat | sat;
         if (!div.singular)
            rsp_data_in[i * m3inv_pkg::ELEM_W +: m3inv_pkg::ELEM_W] =
               div.lane[i].neg ? m3inv_pkg::ELEM_W'(-val) : m3inv_pkg::ELEM_W'(val);
      end
      rsp_user_in = '0;
      rsp_user_in[m3inv_pkg::USER_SINGULAR]  = div.singular;
      rsp_user_in[m3inv_pkg::USER_SATURATED] = any_sat && !div.singular;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `ASSERT_NEVER(a_sing_not_sat, clock, reset, rsp_tvalid && rsp_tuser[m3inv_pkg::USER_SINGULAR] && rsp_tuser[m3inv_pkg::USER_SATURATED])
   `ASSERT_HOLDS(a_sing_zero, clock, reset, (rsp_tvalid && rsp_tuser[m3inv_pkg::USER_SINGULAR]) |-> (rsp_tdata == '0))
   `ASSERT_HOLDS(a_accept_enters, clock, reset, (req_tvalid && req_tready) |=> u_cof.valid1_ff)
endmodule
`default_nettype wire

// ----- src/m3inv_cof.sv -----
// Cofactor stages: eighteen signed products, then nine differences (adjugate).
// Depends on m3inv_pkg.
`default_nettype none
module m3inv_cof (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  m3inv_pkg::mat_type     in_mat,
   output logic                   out_valid,
   output m3inv_pkg::mat_type     out_mat,
   output m3inv_pkg::cof_mat_type out_cof
);
   m3inv_pkg::cof_mat_type pa_in, pb_in, pa_ff, pb_ff, cof_in, cof_ff;
   m3inv_pkg::mat_type     mat1_ff, mat2_ff;
   logic                   valid1_ff, valid2_ff;

   // adj[r][c] is the cofactor of element (c, r)
   for (genvar r = 0; r < m3inv_pkg::N_DIM; r++) begin : g_row
      for (genvar c = 0; c < m3inv_pkg::N_DIM; c++) begin : g_col
         localparam int R1 = (r + 1) % m3inv_pkg::N_DIM;
         localparam int R2 = (r + 2) % m3inv_pkg::N_DIM;
         localparam int C1 = (c + 1) % m3inv_pkg::N_DIM;
         localparam int C2 = (c + 2) % m3inv_pkg::N_DIM;
         assign pa_in[r][c] = $signed(in_mat[C1][R1]) * $signed(in_mat[C2][R2]);
         assign pb_in[r][c] = $signed(in_mat[C1][R2]) * $signed(in_mat[C2][R1]);
         assign cof_in[r][c] = pa_ff[r][c] - pb_ff[r][c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         mat1_ff <= in_mat;
         cof_ff  <= cof_in;
         mat2_ff <= mat1_ff;
      end
   end

   assign out_valid = valid2_ff;
   assign out_mat   = mat2_ff;
   assign out_cof   = cof_ff;
endmodule
`default_nettype wire

// ----- src/m3inv_det.sv -----
// Determinant stages: row 0 times its cofactors, split into 32-bit halves.
// Depends on m3inv_pkg.
`default_nettype none
module m3inv_det (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  m3inv_pkg::mat_type     in_mat,
   input  m3inv_pkg::cof_mat_type in_cof,
   output logic                   out_valid,
   output m3inv_pkg::cof_mat_type out_cof,
   output m3inv_pkg::det_type     out_det
);
   localparam int PL_W = 2 * m3inv_pkg::ELEM_W + 1;
   localparam int PH_W = 2 * m3inv_pkg::ELEM_W;

   logic signed [PL_W-1:0] pl_in [m3inv_pkg::N_DIM];
   logic signed [PL_W-1:0] pl_ff [m3inv_pkg::N_DIM];
   logic signed [PH_W-1:0] ph_in [m3inv_pkg::N_DIM];
   logic signed [PH_W-1:0] ph_ff [m3inv_pkg::N_DIM];
   m3inv_pkg::det_type     term_in [m3inv_pkg::N_DIM];
   m3inv_pkg::det_type     term_ff [m3inv_pkg::N_DIM];
   m3inv_pkg::det_type     det_in, det_ff;
   m3inv_pkg::cof_mat_type cof3_ff, cof4_ff, cof5_ff;
   logic                   valid3_ff, valid4_ff, valid5_ff;

   always_comb begin
      m3inv_pkg::det_type phx, plx;
      for (int j = 0; j < m3inv_pkg::N_DIM; j++) begin
         pl_in[j] = $signed(in_mat[0][j])
                  * $signed({1'b0, in_cof[j][0][m3inv_pkg::ELEM_W-1:0]});
         ph_in[j] = $signed(in_mat[0][j])
                  * $signed(in_cof[j][0][m3inv_pkg::COF_W-1:m3inv_pkg::ELEM_W]);
      end
      for (int j = 0; j < m3inv_pkg::N_DIM; j++) begin
         phx = ph_ff[j];
         plx = pl_ff[j];
         term_in[j] = (phx <<< m3inv_pkg::ELEM_W) + plx;
      end
      det_in = term_ff[0] + term_ff[1] + term_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else if (en) begin
         valid3_ff <= in_valid;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         term_ff <= term_in;
         det_ff  <= det_in;
         cof3_ff <= in_cof;
         cof4_ff <= cof3_ff;
         cof5_ff <= cof4_ff;
      end
   end

   assign out_valid = valid5_ff;
   assign out_cof   = cof5_ff;
   assign out_det   = det_ff;
endmodule
`default_nettype wire

// ----- src/m3inv_div.sv -----
// Nine parallel restoring dividers, one quotient bit per pipeline stage.
// Two prep stages take magnitudes and flag quotients of 2^QUO_W or more.
// Depends on m3inv_pkg.
`default_nettype none
module m3inv_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  m3inv_pkg::cof_mat_type in_cof,
   input  m3inv_pkg::det_type     in_det,
   output logic                   out_valid,
   output m3inv_pkg::div_type     out_div
);
   localparam int NSTG = m3inv_pkg::QUO_W;

   logic [m3inv_pkg::COF_W-1:0] cm_in [m3inv_pkg::N_ELEM];
   logic [m3inv_pkg::COF_W-1:0] cm_ff [m3inv_pkg::N_ELEM];
   logic [m3inv_pkg::N_ELEM-1:0] neg_in, neg_ff;
   logic [m3inv_pkg::MAG_W-1:0]  dmag_in, dmag_ff;
   logic                         dneg, sing_in, sing_ff, pvalid_ff;
   m3inv_pkg::div_type           stg_in;
   m3inv_pkg::div_type           stg_ff [NSTG+1];
   logic                         vld_ff [NSTG+1];

   function automatic m3inv_pkg::lane_type div_step(m3inv_pkg::lane_type l,
                                                    logic [m3inv_pkg::MAG_W-1:0] d);
      logic [m3inv_pkg::MAG_W:0] trial;
      m3inv_pkg::lane_type       r;
      r     = l;
      trial = {l.rem, l.tail[m3inv_pkg::QUO_W-1]};
      r.tail = {l.tail[m3inv_pkg::QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
         r.rem = m3inv_pkg::MAG_W'(trial - {1'b0, d});
         r.quo = {l.quo[m3inv_pkg::QUO_W-2:0], 1'b1};
      end else begin
         r.rem = trial[m3inv_pkg::MAG_W-1:0];
         r.quo = {l.quo[m3inv_pkg::QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // prep stage 1: magnitudes and result signs
   always_comb begin
      dneg    = in_det[m3inv_pkg::DET_W-1];
      dmag_in = dneg ? m3inv_pkg::MAG_W'(-in_det) : m3inv_pkg::MAG_W'(in_det);
      sing_in = (in_det == '0);
      for (int i = 0; i < m3inv_pkg::N_ELEM; i++) begin
         cm_in[i]  = in_cof[i / m3inv_pkg::N_DIM][i % m3inv_pkg::N_DIM][m3inv_pkg::COF_W-1]
                   ? m3inv_pkg::COF_W'(-in_cof[i / m3inv_pkg::N_DIM][i % m3inv_pkg::N_DIM])
                   : in_cof[i / m3inv_pkg::N_DIM][i % m3inv_pkg::N_DIM];
         neg_in[i] = in_cof[i / m3inv_pkg::N_DIM][i % m3inv_pkg::N_DIM][m3inv_pkg::COF_W-1]
                   ^ dneg;
      end
   end

   // prep stage 2: split numerator, overflow when the upper part reaches the divisor
   always_comb begin
      logic [m3inv_pkg::NUM_W-1:0]  num;
      logic [m3inv_pkg::HEAD_W-1:0] head;
      stg_in.dmag     = dmag_ff;
      stg_in.singular = sing_ff;
      for (int i = 0; i < m3inv_pkg::N_ELEM; i++) begin
         num  = m3inv_pkg::NUM_W'(cm_ff[i]) << m3inv_pkg::SHIFT;
         head = num[m3inv_pkg::NUM_W-1:m3inv_pkg::QUO_W];
         stg_in.lane[i].rem  = m3inv_pkg::MAG_W'(head);
         stg_in.lane[i].tail = num[m3inv_pkg::QUO_W-1:0];
         stg_in.lane[i].quo  = '0;
         stg_in.lane[i].neg  = neg_ff[i];
         stg_in.lane[i].ovf  = (m3inv_pkg::MAG_W'(head) >= dmag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         for (int k = 0; k <= NSTG; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         pvalid_ff <= in_valid;
         vld_ff[0] <= pvalid_ff;
         for (int k = 1; k <= NSTG; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cm_ff     <= cm_in;
         neg_ff    <= neg_in;
         dmag_ff   <= dmag_in;
         sing_ff   <= sing_in;
         stg_ff[0] <= stg_in;
         for (int k = 1; k <= NSTG; k++) begin
            stg_ff[k].dmag     <= stg_ff[k-1].dmag;
            stg_ff[k].singular <= stg_ff[k-1].singular;
            for (int i = 0; i < m3inv_pkg::N_ELEM; i++)
               stg_ff[k].lane[i] <= div_step(stg_ff[k-1].lane[i], stg_ff[k-1].dmag);
         end
      end
   end

   assign out_valid = vld_ff[NSTG];
   assign out_div   = stg_ff[NSTG];
endmodule
`default_nettype wire

// ----- dv/matrix3_inverse_checker.sv -----
`timescale 1ns / 1ps
// Checker for the 3x3 matrix inverse: predicts each inverse from the accepted
// request word and compares it with the response word. Needs m3inv_pkg only.
module matrix3_inverse_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   input  logic                                    req_tready,
   input  logic [m3inv_pkg::DATA_W-1:0]            req_tdata,
   input  logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic [m3inv_pkg::DATA_W-1:0]            rsp_tdata,
   input  logic [m3inv_pkg::USER_W-1:0]            rsp_tuser,
   output int                                      fail_count,
   output int                                      pending_count,
   output int                                      singular_seen,
   output int                                      saturated_seen
);
   typedef struct {
      logic [m3inv_pkg::DATA_W-1:0] data;
      logic [m3inv_pkg::USER_W-1:0] user;
   } inverse_word_type;

   inverse_word_type expected_inverses[$];

   // Quotient of cof * 2^32 by det, truncated and clamped to 32 bits.
   function automatic logic [31:0] scaled_quotient(input logic signed [63:0] cof,
                                                   input logic [127:0] dmag,
                                                   input logic dneg,
                                                   inout logic sat);
      logic [127:0] cmag;
      logic [127:0] q;
      logic [127:0] limit;
      logic         neg;
      cmag  = cof < 0 ? 128'(-cof) : 128'(cof);
      neg   = (cof < 0) != dneg;
      q     = (cmag << m3inv_pkg::SHIFT) / dmag;
      limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > limit) begin
         sat = 1'b1;
         q   = limit;
      end
      return neg ? 32'(-q) : q[31:0];
   endfunction

   function automatic inverse_word_type invert(input logic [m3inv_pkg::DATA_W-1:0] data);
      logic signed [63:0]  a [3][3];
      logic signed [63:0]  adj [3][3];
      logic signed [127:0] det;
      logic [127:0]        dmag;
      logic                sat;
      inverse_word_type    w;
      for (int i = 0; i < m3inv_pkg::N_ELEM; i++)
         a[i/3][i%3] = 64'(signed'(data[i*m3inv_pkg::ELEM_W +: m3inv_pkg::ELEM_W]));
      adj[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
      adj[1][0] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
      adj[2][0] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
      adj[0][1] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
      adj[1][1] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
      adj[2][1] = a[0][1]*a[2][0] - a[0][0]*a[2][1];
      adj[0][2] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
      adj[1][2] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
      adj[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
      det = 128'(a[0][0])*128'(adj[0][0]) + 128'(a[0][1])*128'(adj[1][0])
          + 128'(a[0][2])*128'(adj[2][0]);
      w.data = '0;
      w.user = '0;
      if (det == 0) begin
         w.user[m3inv_pkg::USER_SINGULAR] = 1'b1;
         return w;
      end
      dmag = det < 0 ? 128'(-det) : 128'(det);
      sat  = 1'b0;
      for (int i = 0; i < m3inv_pkg::N_ELEM; i++)
         w.data[i*m3inv_pkg::ELEM_W +: m3inv_pkg::ELEM_W] =
            scaled_quotient(adj[i/3][i%3], dmag, det < 0, sat);
      w.user[m3inv_pkg::USER_SATURATED] = sat;
      return w;
   endfunction

   always @(posedge clock) begin
      inverse_word_type want;
      int               errs;
      errs = 0;
      if (reset) begin
         fail_count     <= 0;
         pending_count  <= 0;
         singular_seen  <= 0;
         saturated_seen <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_inverses.push_back(invert(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_inverses.size() == 0) begin
               $error("response word with nothing expected");
               errs++;
            end else begin
               want = expected_inverses.pop_front();
               for (int i = 0; i < m3inv_pkg::N_ELEM; i++)
                  if (want.data[i*m3inv_pkg::ELEM_W +: m3inv_pkg::ELEM_W]
                      !== rsp_tdata[i*m3inv_pkg::ELEM_W +: m3inv_pkg::ELEM_W]) begin
                     $error("out_r%0dc%0d: expected %h, got %h", i/3, i%3,
                            want.data[i*m3inv_pkg::ELEM_W +: m3inv_pkg::ELEM_W],
                            rsp_tdata[i*m3inv_pkg::ELEM_W +: m3inv_pkg::ELEM_W]);
                     errs++;
                  end
               if (want.user[m3inv_pkg::USER_SINGULAR]
                   !== rsp_tuser[m3inv_pkg::USER_SINGULAR]) begin
                  $error("singular: expected %b, got %b",
                         want.user[m3inv_pkg::USER_SINGULAR],
                         rsp_tuser[m3inv_pkg::USER_SINGULAR]);
                  errs++;
               end
               if (want.user[m3inv_pkg::USER_SATURATED]
                   !== rsp_tuser[m3inv_pkg::USER_SATURATED]) begin
                  $error("saturated: expected %b, got %b",
                         want.user[m3inv_pkg::USER_SATURATED],
                         rsp_tuser[m3inv_pkg::USER_SATURATED]);
                  errs++;
               end
               singular_seen  <= singular_seen + want.user[m3inv_pkg::USER_SINGULAR];
               saturated_seen <= saturated_seen + want.user[m3inv_pkg::USER_SATURATED];
            end
         end
         fail_count    <= fail_count + errs;
         pending_count <= expected_inverses.size();
      end
   end
endmodule

// ----- dv/matrix3_inverse_tb.sv -----
`timescale 1ns / 1ps
// Top of the 3x3 matrix inverse testbench: clock, reset, matrix stimulus,
// response back-pressure and verdict. Depends on matrix3_inverse and its checker.
module matrix3_inverse_tb;
   localparam int LATENCY     = 40;
   localparam int CYCLE_LIMIT = 400000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [m3inv_pkg::DATA_W-1:0] req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [m3inv_pkg::DATA_W-1:0] rsp_tdata;
   logic [m3inv_pkg::USER_W-1:0] rsp_tuser;
   int                fail_count, pending_count, singular_seen, saturated_seen;
   int                send_idle_pct = 11, recv_idle_pct = 68;
   int                cycle_count = 0;
   int                sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   matrix3_inverse u_dut (.*);

   matrix3_inverse_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("matrix3_inverse_tb NOT OK");
         $finish;
      end
   end

   // Stall the response side at the current rate.
   always @(posedge clock)
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);

   function automatic logic [31:0] random_elem();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
         2: return 32'($signed($urandom_range(0, 64)) - 32);
         3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
         4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
      endcase
   endfunction

   function automatic logic [m3inv_pkg::DATA_W-1:0] random_matrix();
      logic [m3inv_pkg::DATA_W-1:0] m;
      int                           k;
      m = '0;
      for (int i = 0; i < m3inv_pkg::N_ELEM; i++)
         m[i*m3inv_pkg::ELEM_W +: m3inv_pkg::ELEM_W] = random_elem();
      k = $urandom_range(9);
      // Make some matrices singular: copy or zero a row.
      if (k == 0)
         m[3*m3inv_pkg::ELEM_W +: 3*m3inv_pkg::ELEM_W] = m[0 +: 3*m3inv_pkg::ELEM_W];
      else if (k == 1)
         m[6*m3inv_pkg::ELEM_W +: 3*m3inv_pkg::ELEM_W] = '0;
      return m;
   endfunction

   function automatic logic [m3inv_pkg::DATA_W-1:0] diag_matrix(input logic [31:0] d0,
                                                                input logic [31:0] d1,
                                                                input logic [31:0] d2);
      logic [m3inv_pkg::DATA_W-1:0] m;
      m = '0;
      m[0 +: 32]   = d0;
      m[128 +: 32] = d1;
      m[256 +: 32] = d2;
      return m;
   endfunction

   // Hold valid low while idling; keep it high into the next word otherwise.
   task automatic send_matrix(input logic [m3inv_pkg::DATA_W-1:0] m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= m;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++)
         send_matrix(random_matrix());
   endtask

   initial begin
      logic [m3inv_pkg::DATA_W-1:0] m;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: identity, scaled diagonals, extremes, singular cases.
      send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      send_matrix(diag_matrix(32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000));
      send_matrix(diag_matrix(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
      send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_matrix(diag_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_matrix(diag_matrix(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF));
      send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0000_0000));
      send_matrix('0);
      send_matrix({m3inv_pkg::N_ELEM{32'h8000_0000}});
      send_matrix({m3inv_pkg::N_ELEM{32'h7FFF_FFFF}});
      send_matrix({m3inv_pkg::N_ELEM{32'hFFFF_FFFF}});
      m = diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      m[32 +: 32] = 32'h0003_0000;
      m[224 +: 32] = 32'hFFFE_0000;
      send_matrix(m);
      for (int i = 0; i < 8; i++)
         send_matrix(random_matrix());
      run_random(260);
      send_idle_pct = 68;
      recv_idle_pct = 11;
      run_random(260);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(260);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d matrices; %0d singular and %0d saturated inverses checked.",
               sent, singular_seen, saturated_seen);
      if (fail_count == 0 && pending_count == 0)
         $display("matrix3_inverse_tb OK");
      else
         $display("matrix3_inverse_tb NOT OK");
      $finish;
   end
endmodule
